@@ rtl/dtm_pkg.sv @@
package dtm_pkg;

  localparam int unsigned DutyW   = 8;
  localparam int unsigned ValueW  = 9;
  localparam int unsigned OpW     = 2;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [OpW-1:0] {
    OP_SET_SPEED = 2'd0,
    OP_SET_TURN  = 2'd1,
    OP_TICK      = 2'd2
  } opcode_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEADBAND_LOW  = 2'd0,
    REG_DEADBAND_HIGH = 2'd1,
    REG_SLOW_FWD_LIM  = 2'd2,
    REG_FAST_REV_LIM  = 2'd3
  } cfg_reg_t;

  localparam logic [DutyW-1:0] DeadbandLowReset  = 8'h76;
  localparam logic [DutyW-1:0] DeadbandHighReset = 8'h89;
  localparam logic [DutyW-1:0] SlowFwdLimReset   = 8'd64;
  localparam logic [DutyW-1:0] FastRevLimReset   = 8'd191;
  localparam logic [DutyW-1:0] TurnCenter        = 8'd128;
  localparam logic [DutyW-1:0] FullDuty          = 8'hFF;

  // snapshot of everything the mixer needs for one tick
  typedef struct packed {
    logic [DutyW-1:0] speed;
    logic             rev;
    logic [DutyW-1:0] turn;
    logic [DutyW-1:0] db_low;
    logic [DutyW-1:0] db_high;
    logic [DutyW-1:0] slow_lim;
    logic [DutyW-1:0] fast_lim;
  } mix_req_t;

endpackage

@@ rtl/differential_drive_turn_mixer_core.sv @@
// Speed/turn mixer for a two-sided drive.
// Input channel (in_valid / in_stall) carries one command word: opcode and
// value. Set-speed and set-turn words only update internal state; a pilot
// tick word produces one output word if a command arrived since the last
// tick, otherwise nothing.
// Output channel (out_valid / out_stall) carries left/right duty and
// direction. Configuration (deadbands, speed limits) is written through
// cfg_write / cfg_index / cfg_data; the user must write it only while the
// block is idle, and the block itself does not enforce this.
// Throughput: one input word per cycle while in_stall is low. An accepted
// tick loads the request register, then its mix loads the output register
// and raises out_valid; the mix is one multiply between those two registers.
// When the receiver stalls, the output word holds; one more tick result can
// wait in the request register, after which in_stall rises until the
// output drains. Speed and turn commands are accepted whenever in_stall is low.
// Reset (rst, synchronous) restores default configuration, zero forward
// speed, centered turn, no pending update and empties both registers.
module differential_drive_turn_mixer_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [dtm_pkg::OpW-1:0]     opcode,
  input  logic [dtm_pkg::ValueW-1:0]  value,
  input  logic                        cfg_write,
  input  logic [dtm_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [dtm_pkg::DutyW-1:0]   cfg_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [dtm_pkg::DutyW-1:0]   left_duty,
  output logic                        left_reverse,
  output logic [dtm_pkg::DutyW-1:0]   right_duty,
  output logic                        right_reverse
);

  logic              req_valid;
  logic              req_ready;
  dtm_pkg::mix_req_t req;

  dtm_cmd u_cmd (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .value     (value),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_ready (req_ready),
    .req_valid (req_valid),
    .req       (req)
  );

  dtm_mix u_mix (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req           (req),
    .req_ready     (req_ready),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .left_duty     (left_duty),
    .left_reverse  (left_reverse),
    .right_duty    (right_duty),
    .right_reverse (right_reverse)
  );

endmodule

@@ rtl/dtm_cmd.sv @@
module dtm_cmd (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [dtm_pkg::OpW-1:0]         opcode,
  input  logic [dtm_pkg::ValueW-1:0]      value,
  input  logic                            cfg_write,
  input  logic [dtm_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [dtm_pkg::DutyW-1:0]       cfg_data,
  input  logic                            req_ready,
  output logic                            req_valid,
  output dtm_pkg::mix_req_t               req
);

  logic [dtm_pkg::DutyW-1:0] speed;
  logic                      gen_rev;
  logic [dtm_pkg::DutyW-1:0] turn;
  logic                      pending;
  logic [dtm_pkg::DutyW-1:0] db_low;
  logic [dtm_pkg::DutyW-1:0] db_high;
  logic [dtm_pkg::DutyW-1:0] slow_lim;
  logic [dtm_pkg::DutyW-1:0] fast_lim;
  logic                      accept;
  logic                      tick_fire;
  dtm_pkg::opcode_t          op;

  assign op        = dtm_pkg::opcode_t'(opcode);
  assign in_stall  = req_valid && !req_ready;
  assign accept    = in_valid && !in_stall;
  assign tick_fire = accept && (op == dtm_pkg::OP_TICK) && pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      db_low   <= dtm_pkg::DeadbandLowReset;
      db_high  <= dtm_pkg::DeadbandHighReset;
      slow_lim <= dtm_pkg::SlowFwdLimReset;
      fast_lim <= dtm_pkg::FastRevLimReset;
    end else if (cfg_write) begin
      case (dtm_pkg::cfg_reg_t'(cfg_index))
        dtm_pkg::REG_DEADBAND_LOW:  db_low   <= cfg_data;
        dtm_pkg::REG_DEADBAND_HIGH: db_high  <= cfg_data;
        dtm_pkg::REG_SLOW_FWD_LIM:  slow_lim <= cfg_data;
        dtm_pkg::REG_FAST_REV_LIM:  fast_lim <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speed   <= '0;
      gen_rev <= 1'b0;
      turn    <= dtm_pkg::TurnCenter;
      pending <= 1'b0;
    end else if (accept) begin
      case (op)
        dtm_pkg::OP_SET_SPEED: begin
          // bit 8 set: forward; clear: reverse with inverted magnitude
          gen_rev <= !value[dtm_pkg::ValueW-1];
          speed   <= value[dtm_pkg::ValueW-1] ? value[dtm_pkg::DutyW-1:0]
                                              : ~value[dtm_pkg::DutyW-1:0];
          pending <= 1'b1;
        end
        dtm_pkg::OP_SET_TURN: begin
          turn    <= (value[dtm_pkg::DutyW-1:0] == '0) ? dtm_pkg::DutyW'(1)
                                                       : value[dtm_pkg::DutyW-1:0];
          pending <= 1'b1;
        end
        dtm_pkg::OP_TICK: begin
          pending <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (tick_fire) begin
      req_valid <= 1'b1;
    end else if (req_ready) begin
      req_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_fire) begin
      req.speed    <= speed;
      req.rev      <= gen_rev;
      req.turn     <= turn;
      req.db_low   <= db_low;
      req.db_high  <= db_high;
      req.slow_lim <= slow_lim;
      req.fast_lim <= fast_lim;
    end
  end

  a_tick_loads: assert property (@(posedge clk) disable iff (rst)
    tick_fire |=> req_valid && !pending)
    else $error("tick with pending command did not issue a mix request");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> req_valid)
    else $error("input stalled with empty request stage");

  a_turn_nonzero: assert property (@(posedge clk) disable iff (rst)
    turn != '0)
    else $error("stored turn setting is zero");

endmodule

@@ rtl/dtm_mix.sv @@
module dtm_mix (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  input  dtm_pkg::mix_req_t         req,
  output logic                      req_ready,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [dtm_pkg::DutyW-1:0] left_duty,
  output logic                      left_reverse,
  output logic [dtm_pkg::DutyW-1:0] right_duty,
  output logic                      right_reverse
);

  localparam int unsigned FW   = dtm_pkg::DutyW + 1;   // signed turn fraction
  localparam int unsigned MW   = dtm_pkg::DutyW + 1;   // multiplier factor, up to 382
  localparam int unsigned PW   = dtm_pkg::DutyW + MW;
  localparam int unsigned Frac = 7;                     // 1/128 units

  logic                       turn_right;
  logic                       turn_left;
  logic                       slow;
  logic signed [FW-1:0]       frac;
  logic signed [FW:0]         lin;
  logic [MW-1:0]              factor;
  logic [dtm_pkg::DutyW-1:0]  mult_a;
  logic [PW-1:0]              prod;
  logic [PW-Frac-1:0]         quo;
  logic [dtm_pkg::DutyW-1:0]  inner;
  logic [dtm_pkg::DutyW-1:0]  outer;
  logic                       inner_flip;
  logic [dtm_pkg::DutyW-1:0]  l_duty_next;
  logic [dtm_pkg::DutyW-1:0]  r_duty_next;
  logic                       l_rev_next;
  logic                       r_rev_next;

  assign req_ready = !out_valid || !out_stall;

  always_comb begin
    turn_right = req.turn > req.db_high;
    turn_left  = !turn_right && (req.turn < req.db_low);
    slow = (!req.rev && (req.speed < req.slow_lim)) ||
           ( req.rev && (req.speed > req.fast_lim));
    if (turn_right) begin
      frac = $signed({1'b0, req.turn}) - $signed({1'b0, dtm_pkg::TurnCenter});
    end else begin
      frac = $signed({1'b0, dtm_pkg::TurnCenter}) - $signed({1'b0, req.turn});
    end
    // 128 - 2f stays within -126..382 for any stored turn setting
    lin = $signed({2'b00, dtm_pkg::TurnCenter}) - ($signed({frac[FW-1], frac}) <<< 1);
    if (slow) begin
      mult_a = req.speed;
      if (frac > $signed(FW'(64))) begin
        factor     = MW'(frac - $signed(FW'(64)));
        inner_flip = 1'b1;
      end else begin
        factor     = lin[MW-1:0];
        inner_flip = 1'b0;
      end
    end else begin
      mult_a     = dtm_pkg::FullDuty;
      factor     = (frac > $signed(FW'(0))) ? MW'(frac) : '0;
      inner_flip = 1'b1;
    end
    prod  = PW'(mult_a) * PW'(factor);
    quo   = prod[PW-1:Frac];
    inner = (quo > (PW-Frac)'(dtm_pkg::FullDuty)) ? dtm_pkg::FullDuty
                                                  : quo[dtm_pkg::DutyW-1:0];
    outer = slow ? req.speed : inner;

    l_duty_next = req.speed;
    r_duty_next = req.speed;
    l_rev_next  = req.rev;
    r_rev_next  = req.rev;
    if (turn_right) begin
      r_duty_next = inner;
      l_duty_next = outer;
      r_rev_next  = req.rev ^ inner_flip;
    end else if (turn_left) begin
      l_duty_next = inner;
      r_duty_next = outer;
      l_rev_next  = req.rev ^ inner_flip;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (req_ready) begin
      out_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      left_duty     <= l_duty_next;
      left_reverse  <= l_rev_next;
      right_duty    <= r_duty_next;
      right_reverse <= r_rev_next;
    end
  end

  a_req_to_out: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> out_valid)
    else $error("accepted mix request produced no output word");

  a_one_side_flipped: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !(left_reverse != $past(req.rev) &&
                                 right_reverse != $past(req.rev)))
    else $error("both sides reversed against commanded direction");

  a_straight_equal: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && !turn_right && !turn_left |=>
      left_duty == right_duty && left_reverse == right_reverse)
    else $error("straight mix gave unequal sides");

endmodule
